### hdl/mpr_pkg.sv
// Marking page replacement: shared types and constants.
// No dependencies; imported by mpr_core, marking_page_replacement_unit and mpr_checker.
package mpr_pkg;

    localparam int SLOT_W     = 7;
    localparam int PAGE_W     = 16;
    localparam int START_W    = 7;
    localparam int CFG_W      = 8;
    localparam int MISS_W     = 32;
    localparam logic [CFG_W-1:0] SLOTS_RESET = 8'd128;

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_LOOK  = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_CLEAR = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              phase_reset;
        logic [MISS_W-1:0] miss_total;
    } result_t;

endpackage

### hdl/mpr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/mpr_core.sv
// Sequencer and shared slot walker: lookup, victim scan, phase clear, install.
// Depends on mpr_pkg; drives the key/valid RAM and the mark RAM.
module mpr_core
    import mpr_pkg::*;
#(
    parameter int ENTRIES  = 128,
    parameter int KEY_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [$clog2(ENTRIES)-1:0] last_idx,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [PAGE_W-1:0]          page,
    input  logic [START_W-1:0]         random_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output result_t                    res,
    output logic                       kram_we,
    output logic [$clog2(ENTRIES)-1:0] kram_waddr,
    output logic [KEY_BITS:0]          kram_wdata,
    input  logic [KEY_BITS:0]          kram_rdata,
    output logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic                       mram_we,
    output logic [$clog2(ENTRIES)-1:0] mram_waddr,
    output logic                       mram_wdata,
    input  logic                       mram_rdata
);

    localparam int AW = $clog2(ENTRIES);
    localparam int SW = (AW > START_W) ? AW : START_W;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(ENTRIES - 1);

    state_t               state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 iss_reg, iss_next;
    logic                 up_reg, up_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [AW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MISS_W-1:0]    miss_reg, miss_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [AW-1:0]        start_reg, start_next;
    logic [AW-1:0]        victim_reg, victim_next;
    logic                 phase_reg, phase_next;
    result_t              res_reg, res_next;
    result_t              out_reg, out_next;

    logic [SW-1:0]        start_ext;
    logic [SW-1:0]        last_ext;
    logic [AW-1:0]        start_sat;
    logic                 key_hit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign res       = out_reg;
    assign rd_addr   = idx_reg;

    assign start_ext = SW'(random_start);
    assign last_ext  = SW'(last_idx);
    assign start_sat = (start_ext > last_ext) ? last_idx : AW'(start_ext);
    assign key_hit   = kram_rdata[KEY_BITS] && (kram_rdata[KEY_BITS-1:0] == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        iss_next       = iss_reg;
        up_next        = up_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        miss_next      = miss_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        start_next     = start_reg;
        victim_next    = victim_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        kram_we        = 1'b0;
        kram_waddr     = idx_reg;
        kram_wdata     = '0;
        mram_we        = 1'b0;
        mram_waddr     = idx_reg;
        mram_wdata     = 1'b0;

        // shared walker: issue one read per cycle, check it the next cycle
        if (state_reg == ST_LOOK || state_reg == ST_SCAN)
        begin
            chk_vld_next = iss_reg;
            chk_idx_next = idx_reg;
            if (iss_reg)
            begin
                if (up_reg)
                begin
                    if (idx_reg == last_reg)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (idx_reg == '0)
                begin
                    if (start_reg == last_reg)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        up_next  = 1'b1;
                        idx_next = start_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end

        case (state_reg)
            ST_INIT:
            begin
                kram_we    = 1'b1;
                mram_we    = 1'b1;
                if (idx_reg == LAST_ENTRY)
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = KEY_BITS'(page);
                    start_next = start_sat;
                    last_next  = last_idx;
                    idx_next   = '0;
                    iss_next   = 1'b1;
                    up_next    = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (chk_vld_reg && key_hit)
                begin
                    mram_we                = 1'b1;
                    mram_waddr             = chk_idx_reg;
                    mram_wdata             = 1'b1;
                    res_next.hit           = 1'b1;
                    res_next.slot          = SLOT_W'(chk_idx_reg);
                    res_next.phase_reset   = 1'b0;
                    res_next.miss_total    = miss_reg;
                    state_next             = ST_DONE;
                end
                else if (chk_vld_reg && chk_idx_reg == last_reg)
                begin
                    idx_next     = start_reg;
                    iss_next     = 1'b1;
                    up_next      = 1'b0;
                    chk_vld_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg && !mram_rdata)
                begin
                    victim_next = chk_idx_reg;
                    phase_next  = 1'b0;
                    state_next  = ST_WRITE;
                end
                else if (!chk_vld_reg && !iss_reg)
                begin
                    // every slot in use is marked: new phase
                    victim_next = start_reg;
                    phase_next  = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                mram_we = 1'b1;
                if (idx_reg == last_reg)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                kram_we              = 1'b1;
                kram_waddr           = victim_reg;
                kram_wdata           = {1'b1, key_reg};
                mram_we              = 1'b1;
                mram_waddr           = victim_reg;
                mram_wdata           = 1'b1;
                miss_next            = miss_reg + 1'b1;
                res_next.hit         = 1'b0;
                res_next.slot        = SLOT_W'(victim_reg);
                res_next.phase_reset = phase_reg;
                res_next.miss_total  = miss_reg + 1'b1;
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            iss_reg       <= 1'b0;
            up_reg        <= 1'b1;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            miss_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            iss_reg       <= iss_next;
            up_reg        <= up_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
            miss_reg      <= miss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        last_reg    <= last_next;
        key_reg     <= key_next;
        start_reg   <= start_next;
        victim_reg  <= victim_next;
        phase_reg   <= phase_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

endmodule

### hdl/marking_page_replacement_unit.sv
// Marking page replacement unit, top level: config register, slot RAMs, sequencer.
// Depends on mpr_pkg, mpr_ram, mpr_core.
//
//  channel  signals                                   handshake
//  input    page, random_start                        in_valid / in_ready
//  output   hit, slot, phase_reset, miss_total        out_valid / out_ready
//  config   cfg_write_data                            cfg_write_en (no wait)
//
// Hit: the lookup walks the slots in use, one slot read per cycle through the RAM port.
// Miss: lookup, then victim scan, then install; a new phase adds a mark clear before the install.
// After reset a clearing pass over all ENTRIES slots runs before the first word is accepted.
// One word is worked at a time; the next is taken while a result word waits in the output
// register.
module marking_page_replacement_unit
    import mpr_pkg::*;
#(
    parameter int ENTRIES  = 128,
    parameter int KEY_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CFG_W-1:0]   cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PAGE_W-1:0]  page,
    input  logic [START_W-1:0] random_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot,
    output logic               phase_reset,
    output logic [MISS_W-1:0]  miss_total
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    logic [CFG_W-1:0]   slots_reg;
    logic [CW-1:0]      slots_ext;
    logic [AW-1:0]      last_idx;
    result_t            res;

    logic               kram_we;
    logic [AW-1:0]      kram_waddr;
    logic [KEY_BITS:0]  kram_wdata;
    logic [KEY_BITS:0]  kram_rdata;
    logic [AW-1:0]      rd_addr;
    logic               mram_we;
    logic [AW-1:0]      mram_waddr;
    logic               mram_wdata;
    logic               mram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_write_en)
        begin
            slots_reg <= cfg_write_data;
        end
    end

    assign slots_ext = CW'(slots_reg);

    always_comb
    begin
        if (slots_ext == '0)
        begin
            last_idx = '0;
        end
        else if (slots_ext > CW'(ENTRIES))
        begin
            last_idx = AW'(ENTRIES - 1);
        end
        else
        begin
            last_idx = AW'(slots_ext - 1'b1);
        end
    end

    mpr_ram #(
        .WIDTH (KEY_BITS + 1),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (kram_we),
        .waddr (kram_waddr),
        .wdata (kram_wdata),
        .raddr (rd_addr),
        .rdata (kram_rdata)
    );

    mpr_ram #(
        .WIDTH (1),
        .DEPTH (ENTRIES)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mram_we),
        .waddr (mram_waddr),
        .wdata (mram_wdata),
        .raddr (rd_addr),
        .rdata (mram_rdata)
    );

    mpr_core #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .last_idx     (last_idx),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page         (page),
        .random_start (random_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res          (res),
        .kram_we      (kram_we),
        .kram_waddr   (kram_waddr),
        .kram_wdata   (kram_wdata),
        .kram_rdata   (kram_rdata),
        .rd_addr      (rd_addr),
        .mram_we      (mram_we),
        .mram_waddr   (mram_waddr),
        .mram_wdata   (mram_wdata),
        .mram_rdata   (mram_rdata)
    );

    assign hit         = res.hit;
    assign slot        = res.slot;
    assign phase_reset = res.phase_reset;
    assign miss_total  = res.miss_total;

endmodule

### hdl/mpr_checker.sv
// Port-level checks for marking_page_replacement_unit, attached by bind.
// Depends on mpr_pkg.
module mpr_checker
    import mpr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               hit,
    input logic [SLOT_W-1:0]  slot,
    input logic               phase_reset,
    input logic [MISS_W-1:0]  miss_total
);

    // a waiting result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(hit)
            && $stable(phase_reset) && $stable(miss_total))
        else $error("result word changed while stalled");

    // a pending input word is not dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word withdrawn");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // a hit never starts a new phase
    a_hit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !phase_reset)
        else $error("phase reset on a hit");

endmodule

bind marking_page_replacement_unit mpr_checker u_mpr_checker (.*);
